FILE: rtl/core/csbc_pkg.sv
// Package: types, constants and lexer modes for the C source bracket checker.
`timescale 1ns / 1ps
`default_nettype none
package csbc_pkg;

  localparam int StackDepth = 64;
  localparam int LineBits   = 24;
  localparam int PtrBits    = $clog2(StackDepth);
  localparam int FillBits   = $clog2(StackDepth + 1);
  localparam int QueueDepth = 2;

  localparam logic [7:0] ChOpenParen  = 8'h28;
  localparam logic [7:0] ChOpenBrace  = 8'h7B;
  localparam logic [7:0] ChCloseParen = 8'h29;
  localparam logic [7:0] ChCloseBrace = 8'h7D;
  localparam logic [7:0] ChSlash      = 8'h2F;
  localparam logic [7:0] ChStar       = 8'h2A;
  localparam logic [7:0] ChNewline    = 8'h0A;
  localparam logic [7:0] ChBackslash  = 8'h5C;
  localparam logic [7:0] ChDquote     = 8'h22;
  localparam logic [7:0] ChSquote     = 8'h27;

  localparam logic [1:0] ErrNone     = 2'd0;
  localparam logic [1:0] ErrCloser   = 2'd1;
  localparam logic [1:0] ErrUnclosed = 2'd2;
  localparam logic [1:0] ErrOverflow = 2'd3;

  typedef enum logic [3:0] {
    ModeCode, ModeSlash, ModeLineCmt, ModeBlock, ModeBlockStar,
    ModeStr, ModeStrEsc, ModeChr, ModeChrEsc
  } lex_mode_t;

  typedef enum logic [1:0] {OpNone, OpOpen, OpClose, OpEnd} op_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] text_byte;
  } in_item_t;

  typedef struct packed {
    logic        bracket_seen;
    logic [7:0]  bracket_char;
    logic [1:0]  error_kind;
    logic [7:0]  error_char;
    logic [23:0] error_line;
    logic [15:0] error_total;
  } out_item_t;

  // Classified beat handed from the lexer to the stack engine.
  typedef struct packed {
    op_t                 op;
    logic [7:0]          ch;
    logic [LineBits-1:0] line;
  } cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/csbc_lexer.sv
// Front end: lexer mode, line counter and bracket classification.
`timescale 1ns / 1ps
`default_nettype none
module csbc_lexer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire csbc_pkg::in_item_t in_item,
  input  wire logic              in_fire,
  output csbc_pkg::cmd_t         cmd
);
  import csbc_pkg::*;

  lex_mode_t           mode, mode_next;
  logic [LineBits-1:0] line, line_next;
  logic                code_now;

  always_comb begin
    logic [7:0] b;
    b = in_item.text_byte;
    mode_next = mode;
    code_now = 1'b0;
    unique case (mode)
      ModeSlash: begin
        if (b == ChSlash) mode_next = ModeLineCmt;
        else if (b == ChStar) mode_next = ModeBlock;
        else code_now = 1'b1;
      end
      ModeLineCmt: if (b == ChNewline) mode_next = ModeCode;
      ModeBlock: if (b == ChStar) mode_next = ModeBlockStar;
      ModeBlockStar: begin
        if (b == ChSlash) mode_next = ModeCode;
        else if (b != ChStar) mode_next = ModeBlock;
      end
      ModeStr: begin
        if (b == ChBackslash) mode_next = ModeStrEsc;
        else if (b == ChDquote) mode_next = ModeCode;
      end
      ModeStrEsc: mode_next = ModeStr;
      ModeChr: begin
        if (b == ChBackslash) mode_next = ModeChrEsc;
        else if (b == ChSquote) mode_next = ModeCode;
      end
      ModeChrEsc: mode_next = ModeChr;
      default: code_now = 1'b1;
    endcase
    cmd.op   = OpNone;
    cmd.ch   = b;
    cmd.line = line;
    if (code_now) begin
      mode_next = ModeCode;
      if (b == ChDquote) mode_next = ModeStr;
      else if (b == ChSquote) mode_next = ModeChr;
      else if (b == ChSlash) mode_next = ModeSlash;
      else if (b == ChOpenParen || b == ChOpenBrace) cmd.op = OpOpen;
      else if (b == ChCloseParen || b == ChCloseBrace) cmd.op = OpClose;
    end
    line_next = line;
    if (b == ChNewline && line != {LineBits{1'b1}}) line_next = line + 1'b1;
    if (in_item.req_type) begin
      cmd.op    = OpEnd;
      mode_next = ModeCode;
      line_next = {{(LineBits-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ModeCode;
      line <= {{(LineBits-1){1'b0}}, 1'b1};
    end else if (in_fire) begin
      mode <= mode_next;
      line <= line_next;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/csbc_cmd_fifo.sv
// Short queue between the lexer and the stack engine.
`timescale 1ns / 1ps
`default_nettype none
module csbc_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire csbc_pkg::cmd_t push_data,
  output logic                full,
  input  wire logic           pop,
  output csbc_pkg::cmd_t      pop_data,
  output logic                empty
);
  import csbc_pkg::*;

  cmd_t slots [QueueDepth];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'(QueueDepth));
  assign empty    = (count == 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && !empty) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push && !full} - {1'b0, pop && !empty};
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/csbc_stack.sv
// Back end: shifting opener stack, error counting and result register.
`timescale 1ns / 1ps
`default_nettype none
module csbc_stack (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire csbc_pkg::cmd_t  cmd,
  input  wire logic            cmd_valid,
  output logic                 cmd_take,
  output csbc_pkg::out_item_t  result,
  output logic                 empty,
  input  wire logic            pop
);
  import csbc_pkg::*;

  logic                kinds [StackDepth];
  logic [LineBits-1:0] lines [StackDepth];
  logic [FillBits-1:0] fill;
  logic [15:0]         errors;
  logic                res_valid;

  logic [StackDepth-1:0] hit;
  logic [StackDepth-1:0] below;
  logic                  found, on_top;
  logic                  want;
  logic [PtrBits-1:0]    top;

  assign cmd_take = cmd_valid && (!res_valid || pop);
  assign empty    = !res_valid;
  assign want     = (cmd.ch == ChCloseBrace);
  assign top      = PtrBits'(fill - 1'b1);

  // Mark the nearest matching opener; every cell at or above it shifts down.
  always_comb begin
    logic seen;
    seen = 1'b0;
    found = 1'b0;
    on_top = 1'b0;
    for (int i = StackDepth - 1; i >= 0; i--) begin
      hit[i] = 1'b0;
      if (FillBits'(i) < fill && kinds[i] == want && !seen) begin
        hit[i] = 1'b1;
        seen = 1'b1;
        found = 1'b1;
        if (FillBits'(i + 1) == fill) on_top = 1'b1;
      end
      below[i] = !seen;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take && cmd.op == OpOpen && fill < FillBits'(StackDepth)) begin
      kinds[fill[PtrBits-1:0]] <= (cmd.ch == ChOpenBrace);
      lines[fill[PtrBits-1:0]] <= cmd.line;
    end else if (cmd_take && cmd.op == OpClose && found) begin
      for (int i = 0; i < StackDepth - 1; i++) begin
        if (below[i] || hit[i]) begin
          kinds[i] <= kinds[i+1];
          lines[i] <= lines[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_t r;
    logic      err;
    if (rst) begin
      fill      <= '0;
      errors    <= '0;
      res_valid <= 1'b0;
    end else begin
      // Hold the result until popped; a new beat replaces it in the same cycle.
      res_valid <= cmd_take || (res_valid && !pop);
      if (cmd_take) begin
        r = '0;
        err = 1'b0;
        unique case (cmd.op)
          OpOpen: begin
            r.bracket_seen = 1'b1;
            r.bracket_char = cmd.ch;
            if (fill >= FillBits'(StackDepth)) begin
              err = 1'b1;
              r.error_kind = ErrOverflow;
            end else fill <= fill + 1'b1;
          end
          OpClose: begin
            r.bracket_seen = 1'b1;
            r.bracket_char = cmd.ch;
            if (!found || !on_top) begin
              err = 1'b1;
              r.error_kind = ErrCloser;
            end
            if (found) fill <= fill - 1'b1;
          end
          OpEnd: begin
            fill <= '0;
            if (errors == 16'd0 && fill != '0) begin
              err = 1'b1;
              r.error_kind = ErrUnclosed;
              r.error_char = kinds[top] ? ChOpenBrace : ChOpenParen;
              r.error_line = 24'(lines[top]);
            end
          end
          default: ;
        endcase
        if (err && cmd.op != OpEnd) begin
          r.error_char = cmd.ch;
          r.error_line = 24'(cmd.line);
        end
        r.error_total = errors + {15'd0, err && errors != 16'hFFFF};
        errors <= (cmd.op == OpEnd) ? 16'd0 : r.error_total;
        result <= r;
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/c_source_bracket_checker.sv
// Top level of the C source bracket checker.
`timescale 1ns / 1ps
`default_nettype none
// Checks that round and curly brackets in C source text pair up. Push one
// beat per source byte (req_type 0) and one end beat (req_type 1) per text;
// each beat yields exactly one result beat. String and character literals
// with escapes, line comments and block comments are skipped, and newlines
// are counted everywhere. The lexer classifies a byte per cycle unless the
// queue is full, feeding a two-entry queue to the stack engine, which searches
// and shifts its 64-entry cell stack at once; one beat per cycle is sustained
// while results are popped. A beat is registered in the queue, then in the
// result register; after the end beat all state resets for the next text.
module c_source_bracket_checker (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire csbc_pkg::in_item_t   in_item,
  input  wire logic                 push,
  output logic                      full,
  output csbc_pkg::out_item_t       out_item,
  output logic                      empty,
  input  wire logic                 pop
);
  import csbc_pkg::*;

  cmd_t lex_cmd, q_cmd;
  logic q_empty, q_take;

  csbc_lexer u_lexer (
    .clk(clk), .rst(rst), .in_item(in_item), .in_fire(push && !full), .cmd(lex_cmd)
  );

  csbc_cmd_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_data(lex_cmd), .full(full),
    .pop(q_take), .pop_data(q_cmd), .empty(q_empty)
  );

  csbc_stack u_stack (
    .clk(clk), .rst(rst), .cmd(q_cmd), .cmd_valid(!q_empty), .cmd_take(q_take),
    .result(out_item), .empty(empty), .pop(pop)
  );
endmodule
`default_nettype wire

FILE: rtl/core/csbc_checker.sv
// Port-level assertions for the C source bracket checker.
`timescale 1ns / 1ps
`default_nettype none
module csbc_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                push,
  input wire logic                full,
  input wire logic                empty,
  input wire logic                pop,
  input wire csbc_pkg::out_item_t out_item
);
  import csbc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_item)) else $error("result dropped");
  a_echo: assert property (@(posedge clk) disable iff (rst)
    !empty && !out_item.bracket_seen |-> out_item.bracket_char == 8'd0)
    else $error("echo without bracket");
  a_nerr: assert property (@(posedge clk) disable iff (rst)
    !empty && out_item.error_kind == ErrNone |-> out_item.error_line == 24'd0)
    else $error("line without error");
  a_rst: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("reset state");
endmodule

bind c_source_bracket_checker csbc_checker u_csbc_checker (
  .clk(clk), .rst(rst), .push(push), .full(full), .empty(empty), .pop(pop),
  .out_item(out_item)
);
`default_nettype wire
